// ===== hw/rtl/tbvp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbvp_pkg
// Shared constants and helpers for the tagged binary value parser.
// ----------------------------------------------------------------------------
package tbvp_pkg;

    localparam int MAX_DEPTH_DEF = 16;
    localparam int TYPE_CODES    = 17;

    localparam logic [2:0] PH_TYPE   = 3'd0;
    localparam logic [2:0] PH_NUM    = 3'd1;
    localparam logic [2:0] PH_STR    = 3'd2;
    localparam logic [2:0] PH_KEYLEN = 3'd3;
    localparam logic [2:0] PH_KEY    = 3'd4;

    localparam logic [7:0] T_FLOAT = 8'd10;
    localparam logic [7:0] T_BOOL  = 8'd11;
    localparam logic [7:0] T_NULL  = 8'd12;
    localparam logic [7:0] T_LIST  = 8'd7;
    localparam logic [7:0] T_MAP   = 8'd8;

    localparam logic [3:0] TK_UINT     = 4'd0;
    localparam logic [3:0] TK_SINT     = 4'd1;
    localparam logic [3:0] TK_FLOAT    = 4'd2;
    localparam logic [3:0] TK_BOOL     = 4'd3;
    localparam logic [3:0] TK_NULL     = 4'd4;
    localparam logic [3:0] TK_STRSTART = 4'd5;
    localparam logic [3:0] TK_STRBYTE  = 4'd6;
    localparam logic [3:0] TK_LIST     = 4'd7;
    localparam logic [3:0] TK_MAP      = 4'd8;
    localparam logic [3:0] TK_KEYSTART = 4'd9;
    localparam logic [3:0] TK_KEYBYTE  = 4'd10;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_TRUNC = 2'd1;
    localparam logic [1:0] ERR_UNK   = 2'd2;
    localparam logic [1:0] ERR_DEEP  = 2'd3;

    // payload bytes per type code, 0 = none / unknown
    function automatic logic [3:0] payload_len(input logic [7:0] t);
        logic [3:0] r;
        begin
            unique case (t)
                8'd0, 8'd4, 8'd11, 8'd13: r = 4'd1;
                8'd1, 8'd5, 8'd14:        r = 4'd2;
                8'd2, 8'd6, 8'd7, 8'd8, 8'd15: r = 4'd4;
                8'd3, 8'd10, 8'd16:       r = 4'd8;
                default:                  r = 4'd0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== hw/rtl/tbvp_stack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbvp_stack
// Container level store: remaining count and map flags per level.
// ----------------------------------------------------------------------------
module tbvp_stack #(
    parameter int MAX_DEPTH = tbvp_pkg::MAX_DEPTH_DEF,
    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_count,
    input  logic          wr_is_map,
    input  logic [AW-1:0] rd_addr,
    output logic [31:0]   rd_count,
    output logic          rd_is_map
);
    logic [31:0] count_mem [MAX_DEPTH];
    logic        map_mem   [MAX_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            count_mem[wr_addr] <= wr_count;
            map_mem[wr_addr]   <= wr_is_map;
        end
        rd_count  <= count_mem[rd_addr];
        rd_is_map <= map_mem[rd_addr];
    end
endmodule

// ===== hw/rtl/tagged_binary_value_parser_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tagged_binary_value_parser_core
// Streaming deserializer for a tagged binary format, one byte per transaction.
// ----------------------------------------------------------------------------
// channel | signals                                         | dir
// in      | in_valid/in_ready, data_byte, end_of_message   | sink
// out     | out_valid/out_ready, token_kind, token_value,   | source
//         | nesting_depth, error_code, message_done        |
// A byte passes through accept, decode, check and output states. Closing a
// value adds a level read and pops each exhausted level by a level read, then
// a decrement/write through the counter unit. Reset clears sequencer and
// pointer; the level store has no reset. A pending result holds the output
// register; the next byte is taken once it leaves. Truncation is checked
// after the pops finish.
// ----------------------------------------------------------------------------
module tagged_binary_value_parser_core #(
    parameter int MAX_DEPTH = tbvp_pkg::MAX_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  token_kind,
    output logic [63:0] token_value,
    output logic [4:0]  nesting_depth,
    output logic [1:0]  error_code,
    output logic        message_done
);
    import tbvp_pkg::*;

    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int PW = $clog2(MAX_DEPTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_POP  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  type_reg, type_next;
    logic [31:0] left_reg, left_next;
    logic [63:0] acc_reg, acc_next;
    logic [PW-1:0] ptr_reg, ptr_next;
    logic        err_l_reg, err_l_next;
    logic [7:0]  byte_reg, byte_next;
    logic        last_reg, last_next;
    logic        tok_reg, tok_next;
    logic [3:0]  kind_reg, kind_next;
    logic [63:0] val_reg, val_next;
    logic [4:0]  dep_reg, dep_next;
    logic [1:0]  err_reg, err_next;
    logic        ov_reg, ov_next;
    logic [3:0]  o_kind_reg, o_kind_next;
    logic [63:0] o_val_reg, o_val_next;
    logic [4:0]  o_dep_reg, o_dep_next;
    logic [1:0]  o_err_reg, o_err_next;
    logic        o_done_reg, o_done_next;

    logic          st_we;
    logic [AW-1:0] st_waddr, st_raddr;
    logic [31:0]   st_wcount, st_rcount;
    logic          st_wmap, st_rmap;
    logic [31:0]   dec_cnt;
    logic [PW-1:0] ptr_m1;

    tbvp_stack #(.MAX_DEPTH(MAX_DEPTH)) u_stack (
        .clk       (clk),
        .wr_en     (st_we),
        .wr_addr   (st_waddr),
        .wr_count  (st_wcount),
        .wr_is_map (st_wmap),
        .rd_addr   (st_raddr),
        .rd_count  (st_rcount),
        .rd_is_map (st_rmap)
    );

    assign ptr_m1   = ptr_reg - PW'(1);
    assign st_raddr = ptr_m1[AW-1:0];
    assign dec_cnt  = st_rcount - 32'd1;

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = ov_reg;
    assign token_kind    = o_kind_reg;
    assign token_value   = o_val_reg;
    assign nesting_depth = o_dep_reg;
    assign error_code    = o_err_reg;
    assign message_done  = o_done_reg;

    always_comb
    begin
        logic [63:0] a;
        logic [31:0] l;
        logic [6:0]  bits;
        state_next = state_reg;  phase_next = phase_reg; type_next = type_reg;
        left_next = left_reg;    acc_next = acc_reg;     ptr_next = ptr_reg;
        err_l_next = err_l_reg;  byte_next = byte_reg;   last_next = last_reg;
        tok_next = tok_reg;      kind_next = kind_reg;   val_next = val_reg;
        dep_next = dep_reg;      err_next = err_reg;     ov_next = ov_reg;
        o_kind_next = o_kind_reg; o_val_next = o_val_reg; o_dep_next = o_dep_reg;
        o_err_next = o_err_reg;  o_done_next = o_done_reg;
        st_we = 1'b0; st_waddr = ptr_reg[AW-1:0]; st_wcount = acc_reg[31:0];
        st_wmap = 1'b0;
        a = '0; l = '0; bits = '0;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    byte_next = data_byte;
                    last_next = end_of_message;
                    tok_next = 1'b0; kind_next = TK_UINT; val_next = '0;
                    err_next = ERR_NONE;
                    dep_next = 5'(ptr_reg);
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                state_next = S_FIN;
                if (err_l_reg)
                begin
                    dep_next = '0;
                end
                else
                begin
                    unique case (phase_reg)
                        PH_TYPE:
                        begin
                            if (byte_reg == T_NULL)
                            begin
                                tok_next = 1'b1; kind_next = TK_NULL;
                                state_next = S_RD;
                            end
                            else if (payload_len(byte_reg) == 4'd0)
                            begin
                                val_next = {56'd0, byte_reg}; err_next = ERR_UNK;
                                err_l_next = 1'b1;
                            end
                            else
                            begin
                                type_next = byte_reg;
                                left_next = {28'd0, payload_len(byte_reg)};
                                acc_next = '0;
                                phase_next = PH_NUM;
                            end
                        end
                        PH_NUM:
                        begin
                            a = {acc_reg[55:0], byte_reg};
                            l = left_reg - 32'd1;
                            acc_next = a;
                            left_next = l;
                            if (l == 32'd0)
                            begin
                                tok_next = 1'b1;
                                val_next = a;
                                if (type_reg <= 8'd3)
                                begin
                                    kind_next = TK_UINT; state_next = S_RD;
                                end
                                else if (type_reg >= 8'd13)
                                begin
                                    kind_next = TK_SINT; state_next = S_RD;
                                    bits = {payload_len(type_reg), 3'd0};
                                    unique case (bits)
                                        7'd8:  val_next = {{56{a[7]}}, a[7:0]};
                                        7'd16: val_next = {{48{a[15]}}, a[15:0]};
                                        7'd32: val_next = {{32{a[31]}}, a[31:0]};
                                        default: val_next = a;
                                    endcase
                                end
                                else if (type_reg == T_FLOAT)
                                begin
                                    kind_next = TK_FLOAT; state_next = S_RD;
                                end
                                else if (type_reg == T_BOOL)
                                begin
                                    kind_next = TK_BOOL; state_next = S_RD;
                                    val_next = {63'd0, a != 64'd0};
                                end
                                else if (type_reg <= 8'd6)
                                begin
                                    kind_next = TK_STRSTART;
                                    val_next = {32'd0, a[31:0]};
                                    if (a[31:0] == 32'd0)
                                        state_next = S_RD;
                                    else
                                    begin
                                        left_next = a[31:0];
                                        phase_next = PH_STR;
                                    end
                                end
                                else
                                begin
                                    kind_next = (type_reg == T_MAP) ? TK_MAP : TK_LIST;
                                    val_next = {32'd0, a[31:0]};
                                    if (a[31:0] == 32'd0)
                                        state_next = S_RD;
                                    else if (ptr_reg >= PW'(MAX_DEPTH))
                                    begin
                                        err_next = ERR_DEEP; err_l_next = 1'b1;
                                    end
                                    else
                                    begin
                                        st_we = 1'b1;
                                        st_wcount = a[31:0];
                                        st_wmap = (type_reg == T_MAP);
                                        ptr_next = ptr_reg + PW'(1);
                                        phase_next = (type_reg == T_MAP) ? PH_KEYLEN
                                                                         : PH_TYPE;
                                    end
                                end
                            end
                        end
                        PH_STR:
                        begin
                            tok_next = 1'b1; kind_next = TK_STRBYTE;
                            val_next = {56'd0, byte_reg};
                            l = left_reg - 32'd1;
                            left_next = l;
                            if (l == 32'd0)
                                state_next = S_RD;
                        end
                        PH_KEYLEN:
                        begin
                            tok_next = 1'b1; kind_next = TK_KEYSTART;
                            val_next = {56'd0, byte_reg};
                            if (byte_reg == 8'd0)
                            begin
                                phase_next = PH_TYPE;
                                if (last_reg)
                                    state_next = S_RD;
                            end
                            else
                            begin
                                left_next = {24'd0, byte_reg};
                                phase_next = PH_KEY;
                            end
                        end
                        default:
                        begin
                            tok_next = 1'b1; kind_next = TK_KEYBYTE;
                            val_next = {56'd0, byte_reg};
                            l = left_reg - 32'd1;
                            left_next = l;
                            if (l == 32'd0)
                            begin
                                phase_next = PH_TYPE;
                                if (last_reg)
                                    state_next = S_RD;
                            end
                        end
                    endcase
                end
            end
            S_RD:
            begin
                phase_next = PH_TYPE;
                if (ptr_reg == '0)
                    state_next = S_FIN;
                else
                    state_next = S_POP;
            end
            S_POP:
            begin
                st_we = 1'b1;
                st_waddr = ptr_m1[AW-1:0];
                st_wcount = dec_cnt;
                st_wmap = st_rmap;
                if (dec_cnt != 32'd0)
                begin
                    phase_next = st_rmap ? PH_KEYLEN : PH_TYPE;
                    state_next = S_FIN;
                end
                else
                begin
                    ptr_next = ptr_m1;
                    state_next = S_RD;
                end
            end
            S_FIN:
            begin
                if (!err_l_reg && last_reg && (phase_reg != PH_TYPE || ptr_reg != '0))
                    err_next = ERR_TRUNC;
                state_next = S_OUT;
            end
            default:
            begin
                if (!ov_reg || out_ready)
                begin
                    if (tok_reg || err_reg != ERR_NONE || last_reg)
                    begin
                        ov_next = 1'b1;
                        o_kind_next = tok_reg ? kind_reg : TK_UINT;
                        o_val_next = (tok_reg || err_reg == ERR_UNK) ? val_reg : '0;
                        o_dep_next = dep_reg;
                        o_err_next = err_reg;
                        o_done_next = last_reg;
                    end
                    if (last_reg)
                    begin
                        phase_next = PH_TYPE; ptr_next = '0; err_l_next = 1'b0;
                        left_next = '0; acc_next = '0; type_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_TYPE;
            type_reg  <= '0;
            left_reg  <= '0;
            acc_reg   <= '0;
            ptr_reg   <= '0;
            err_l_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            type_reg  <= type_next;
            left_reg  <= left_next;
            acc_reg   <= acc_next;
            ptr_reg   <= ptr_next;
            err_l_reg <= err_l_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg    <= byte_next;
        last_reg    <= last_next;
        tok_reg     <= tok_next;
        kind_reg    <= kind_next;
        val_reg     <= val_next;
        dep_reg     <= dep_next;
        err_reg     <= err_next;
        o_kind_reg  <= o_kind_next;
        o_val_reg   <= o_val_next;
        o_dep_reg   <= o_dep_next;
        o_err_reg   <= o_err_next;
        o_done_reg  <= o_done_next;
    end
endmodule

// ===== hw/rtl/tbvp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbvp_checker
// Port-level checks for the parser core.
// ----------------------------------------------------------------------------
module tbvp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  token_kind,
    input logic [63:0] token_value,
    input logic [4:0]  nesting_depth,
    input logic [1:0]  error_code
);
    import tbvp_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(token_value))
        else $error("output transaction dropped or changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready after accepted transaction");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> token_kind <= TK_KEYBYTE)
        else $error("bad token kind");

    a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> nesting_depth <= 5'(MAX_DEPTH_DEF))
        else $error("nesting depth out of range");

    a_unknown_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code == ERR_UNK |-> token_kind == TK_UINT
                                             && token_value[63:8] == 56'd0)
        else $error("unknown type result malformed");
endmodule

bind tagged_binary_value_parser_core tbvp_checker u_tbvp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .token_kind    (token_kind),
    .token_value   (token_value),
    .nesting_depth (nesting_depth),
    .error_code    (error_code)
);
